>>> hdl/msrm_pkg.sv
// Package for the metering SPI register master.
// Holds word types, frame kind and action codes, and sizing constants.
// No dependencies.
package msrm_pkg;

	localparam int DATA_BYTES_DEF = 3;
	localparam int WDATA_W = 24;
	localparam int CNT_W = 6;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	localparam logic [1:0] KIND_CMD = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	localparam logic [7:0] READ_ADDR_MASK = 8'hBF;

	typedef struct packed {
		logic action;
		logic [1:0] frame_kind;
		logic [7:0] addr_cmd;
		logic [WDATA_W-1:0] write_data;
		logic miso;
	} req_t;

	typedef struct packed {
		logic mosi;
		logic cs_n;
		logic bit_active;
		logic done_res;
		logic [WDATA_W-1:0] read_data;
		logic error;
	} rsp_t;

endpackage

>>> hdl/msrm_stream_if.sv
// Valid/ready channel interface carrying one word per handshake.
// The word type is a parameter; used with msrm_pkg word types.
interface msrm_stream_if #(
	parameter type payload_t = logic
) ();
	logic valid;
	logic ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> hdl/metering_spi_register_master.sv
// Metering SPI register master, bit-level frame sequencer.
// The result word is registered; it is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle; input is taken whenever the result register is
// empty or being drained in the same cycle.
// Reset clears the frame state to idle and empties the result register.
module metering_spi_register_master #(
	parameter int DATA_BYTES = msrm_pkg::DATA_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	msrm_stream_if.sink req,
	msrm_stream_if.source rsp
);
	import msrm_pkg::*;

	logic accept;
	logic can_load;
	rsp_t result;

	assign req.ready = can_load;
	assign accept = req.valid && can_load;

	msrm_frame #(
		.DATA_BYTES(DATA_BYTES)
	) u_frame (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.item(req.data),
		.result(result)
	);

	msrm_out_reg u_out_reg (
		.clk(clk),
		.arst_n(arst_n),
		.load(accept),
		.word(result),
		.can_load(can_load),
		.rsp(rsp)
	);

endmodule

>>> hdl/msrm_frame.sv
// Frame state and bit logic of the metering SPI register master.
// Updates the frame state on accepted words that open or advance a frame, and forms the result word.
// Depends on msrm_pkg.
module msrm_frame #(
	parameter int DATA_BYTES = msrm_pkg::DATA_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input msrm_pkg::req_t item,
	output msrm_pkg::rsp_t result
);
	import msrm_pkg::*;

	localparam int DBITS = 8 * DATA_BYTES;

	logic busy_q;
	logic [1:0] kind_q;
	logic [CNT_W-1:0] bit_count_q;
	logic [7:0] addr_q;
	logic [WDATA_W-1:0] wdata_q;
	logic [WDATA_W-1:0] in_shift_q;

	logic [1:0] kind_eff;
	logic [CNT_W-1:0] total;
	logic [CNT_W-1:0] bit_next;
	logic [CNT_W-1:0] data_idx;
	logic [CNT_W-1:0] data_pos;
	logic [WDATA_W-1:0] in_shift_next;
	logic frame_bit;
	logic last_bit;
	logic sample;

	assign kind_eff = (item.frame_kind == KIND_WRITE || item.frame_kind == KIND_READ) ?
		item.frame_kind : KIND_CMD;
	assign total = (kind_q == KIND_WRITE || kind_q == KIND_READ) ?
		CNT_W'(8 + DBITS) : CNT_W'(8);
	assign bit_next = bit_count_q + CNT_W'(1);
	assign last_bit = bit_next >= total;
	assign data_idx = bit_count_q - CNT_W'(8);
	assign data_pos = CNT_W'(DBITS - 1) - data_idx;
	assign sample = (kind_q == KIND_READ) && (bit_count_q >= CNT_W'(8));
	assign in_shift_next = sample ? {in_shift_q[WDATA_W-2:0], item.miso} : in_shift_q;

	always_comb begin
		if (bit_count_q < CNT_W'(8)) begin
			frame_bit = addr_q[3'd7 - bit_count_q[2:0]];
		end else if (kind_q == KIND_READ) begin
			frame_bit = (data_idx[2:0] != 3'd7);
		end else if (data_pos < CNT_W'(WDATA_W)) begin
			frame_bit = wdata_q[data_pos[4:0]];
		end else begin
			frame_bit = 1'b0;
		end
	end

	always_comb begin
		result = '0;
		result.mosi = 1'b1;
		result.cs_n = 1'b1;
		if (item.action == ACT_START) begin
			result.cs_n = 1'b0;
			result.error = busy_q;
		end else if (busy_q) begin
			result.cs_n = 1'b0;
			result.bit_active = 1'b1;
			result.mosi = frame_bit;
			result.done_res = last_bit;
			if (last_bit && kind_q == KIND_READ) begin
				result.read_data = in_shift_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			kind_q <= KIND_CMD;
			bit_count_q <= '0;
			addr_q <= '0;
			wdata_q <= '0;
			in_shift_q <= '0;
		end else if (accept) begin
			if (item.action == ACT_START) begin
				if (!busy_q) begin
					busy_q <= 1'b1;
					kind_q <= kind_eff;
					bit_count_q <= '0;
					addr_q <= (kind_eff == KIND_READ) ? (item.addr_cmd & READ_ADDR_MASK) :
						item.addr_cmd;
					wdata_q <= item.write_data;
					in_shift_q <= '0;
				end
			end else if (busy_q) begin
				bit_count_q <= bit_next;
				in_shift_q <= in_shift_next;
				if (last_bit) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	a_done_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		accept && result.done_res |=> !busy_q)
		else $error("frame still busy after its final bit");

	a_start_opens_frame: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.action == ACT_START && !busy_q |=> busy_q && bit_count_q == '0)
		else $error("start did not open a fresh frame");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> bit_count_q < total)
		else $error("bit count beyond frame length");

	a_rdata_only_on_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.read_data != '0 |-> result.done_res && kind_q == KIND_READ)
		else $error("read data outside the done tick of a read");

endmodule

>>> hdl/msrm_out_reg.sv
// Result register of the metering SPI register master.
// Holds one result word for the output channel; depends on msrm_pkg and msrm_stream_if.
module msrm_out_reg (
	input logic clk,
	input logic arst_n,
	input logic load,
	input msrm_pkg::rsp_t word,
	output logic can_load,
	msrm_stream_if.source rsp
);
	import msrm_pkg::*;

	logic valid_q;
	rsp_t word_q;

	assign can_load = !valid_q || rsp.ready;
	assign rsp.valid = valid_q;
	assign rsp.data = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= word;
		end
	end

endmodule
